@@ hdl/port_link_activity_led_render_defines.svh @@
// Assertion macros shared by the renderer's RTL.
`ifndef PORT_LINK_ACTIVITY_LED_RENDER_DEFINES_SVH
`define PORT_LINK_ACTIVITY_LED_RENDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLAR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/plar_pkg.sv @@
package plar_pkg;

  localparam int unsigned ROM_PORTS = 52;

  typedef struct packed {
    logic       present;
    logic       proc;
    logic [5:0] amber;
  } rom_entry_t;

  typedef struct packed {
    logic [63:0] w1;
    logic [63:0] w0;
  } chain_pair_t;

  localparam logic [63:0] ROM_PROC = 64'h001F_FE00_0000_01FE;

  localparam logic [5:0] ROM_AMBER [64] = '{
    6'd0,
    6'd34, 6'd32, 6'd38, 6'd36, 6'd62, 6'd60, 6'd58, 6'd56,
    6'd2,  6'd0,  6'd6,  6'd4,  6'd50, 6'd48, 6'd54, 6'd52,
    6'd46, 6'd44, 6'd42, 6'd40, 6'd62, 6'd60, 6'd58, 6'd56,
    6'd38, 6'd36, 6'd34, 6'd32, 6'd30, 6'd28, 6'd26, 6'd24,
    6'd14, 6'd8,  6'd10, 6'd12, 6'd22, 6'd20, 6'd18, 6'd16,
    6'd44, 6'd42, 6'd40, 6'd46, 6'd52, 6'd50, 6'd48, 6'd54,
    6'd26, 6'd24, 6'd30, 6'd28,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0
  };

  function automatic rom_entry_t rom_lookup(input logic [7:0] port);
    rom_entry_t e;
    e.present = (port != 8'd0) && (port <= 8'(ROM_PORTS));
    e.proc    = e.present ? ROM_PROC[port[5:0]] : 1'b0;
    e.amber   = e.present ? ROM_AMBER[port[5:0]] : 6'd0;
    return e;
  endfunction

endpackage

@@ hdl/plar_ifs.sv @@
interface plar_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  port_number;
  logic        entry_valid;
  logic        link_up;
  logic [63:0] rx_count;
  logic [63:0] tx_count;

  modport source (output valid, action, port_number, entry_valid, link_up, rx_count,
                  tx_count, input ready);
  modport sink (input valid, action, port_number, entry_valid, link_up, rx_count,
                tx_count, output ready);
endinterface

interface plar_out_if;
  logic        valid;
  logic        ready;
  logic        processor;
  logic [63:0] chain_bits;
  logic        last;

  modport source (output valid, processor, chain_bits, last, input ready);
  modport sink (input valid, processor, chain_bits, last, output ready);
endinterface

@@ hdl/plar_total_store.sv @@
module plar_total_store #(
  parameter int unsigned DEPTH = 53
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [63:0]              rd_total_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [63:0]              wr_data_i
);

  logic [63:0]      mem [DEPTH];
  logic [63:0]      rd_data_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_total_o = rd_vld_q ? rd_data_q : 64'd0;

endmodule

@@ hdl/plar_out_buf.sv @@
module plar_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  plar_pkg::chain_pair_t words_i,
  output logic                  empty_o,
  plar_out_if.source            chain_o
);

  logic [1:0]            cnt_q;
  logic [1:0]            cnt_d;
  plar_pkg::chain_pair_t words_q;

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = 2'd2;
    end else if (chain_o.valid && chain_o.ready) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= words_i;
    end
  end

  assign empty_o            = (cnt_q == 2'd0);
  assign chain_o.valid      = !empty_o;
  assign chain_o.last       = (cnt_q == 2'd1);
  assign chain_o.processor  = (cnt_q == 2'd1);
  assign chain_o.chain_bits = (cnt_q == 2'd2) ? words_q.w0 : words_q.w1;

endmodule

@@ hdl/port_link_activity_led_render.sv @@
// Channel   | Dir | Beat
// ----------+-----+-----------------------------------------------------------
// report_i  | in  | port report or end-of-poll marker
// chain_o   | out | chain word, two per end-of-poll marker (processor 0, then 1)
//
// Reports are taken one per cycle while no end-of-poll marker holds report_i;
// the stored total is read in the cycle a beat is taken and compared and
// written back in the next, with a one-entry bypass. An end-of-poll marker
// that reaches the second stage while chain words of the previous marker are
// still queued holds report_i until both have left, also while chain_o stalls.
// Reset clears the stored totals through per-port valid bits at once.
`include "port_link_activity_led_render_defines.svh"

module port_link_activity_led_render #(
  parameter int unsigned MAX_PORTS   = 52,
  parameter int unsigned BLINK_POLLS = 8,
  parameter int unsigned CHAIN_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plar_in_if.sink    report_i,
  plar_out_if.source chain_o
);

  localparam int unsigned DEPTH  = MAX_PORTS + 1;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SUB_W  = $clog2(BLINK_POLLS + 1);
  localparam logic [63:0] CHAIN_MASK = {64{1'b1}} >> (64 - 8 * CHAIN_BYTES);

  logic              s1_valid_q;
  logic              s1_action_q;
  logic              s1_hit_q;
  logic [7:0]        s1_port_q;
  logic [63:0]       s1_total_q;
  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [63:0]       fwd_total_q;
  logic [63:0]       chain_q [2];
  logic [63:0]       chain_d [2];
  logic [31:0]       poll_q;
  logic [SUB_W-1:0]  sub_q;
  logic              phase_q;

  logic                  buf_empty;
  logic                  s1_go;
  logic                  in_acc;
  logic                  in_hit;
  logic                  marker_go;
  logic                  wr_en;
  logic [ADDR_W-1:0]     s1_addr;
  logic [63:0]           rd_total;
  logic [63:0]           prev_total;
  logic                  active;
  plar_pkg::rom_entry_t  rom;
  logic [5:0]            green;
  plar_pkg::chain_pair_t load_words;

  assign s1_go          = !s1_valid_q || !s1_action_q || buf_empty;
  assign report_i.ready = s1_go;
  assign in_acc         = report_i.valid && s1_go;
  assign in_hit         = !report_i.action && report_i.entry_valid && report_i.link_up &&
                          (report_i.port_number != 8'd0) &&
                          (report_i.port_number <= 8'(MAX_PORTS));

  assign s1_addr    = s1_port_q[ADDR_W-1:0];
  assign marker_go  = s1_valid_q && s1_action_q && buf_empty;
  assign wr_en      = s1_valid_q && !s1_action_q && s1_hit_q;
  assign prev_total = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_total_q : rd_total;
  assign active     = (s1_total_q != prev_total);
  assign rom        = plar_pkg::rom_lookup(s1_port_q);
  assign green      = rom.amber + 6'd1;

  always_comb begin
    chain_d[0] = chain_q[0];
    chain_d[1] = chain_q[1];
    if (marker_go) begin
      chain_d[0] = 64'd0;
      chain_d[1] = 64'd0;
    end else if (wr_en && rom.present && !(active && phase_q)) begin
      chain_d[rom.proc] = chain_q[rom.proc] | (64'd1 << green);
    end
  end

  assign load_words.w0 = chain_q[0] & CHAIN_MASK;
  assign load_words.w1 = chain_q[1] & CHAIN_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      chain_q[0]  <= 64'd0;
      chain_q[1]  <= 64'd0;
      poll_q      <= 32'd0;
      sub_q       <= '0;
      phase_q     <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_valid_q <= in_acc;
      end
      fwd_valid_q <= wr_en;
      chain_q[0]  <= chain_d[0];
      chain_q[1]  <= chain_d[1];
      if (marker_go) begin
        poll_q <= poll_q + 32'd1;
        if (poll_q == {32{1'b1}}) begin
          sub_q   <= '0;
          phase_q <= 1'b0;
        end else if (sub_q == SUB_W'(BLINK_POLLS - 1)) begin
          sub_q   <= '0;
          phase_q <= !phase_q;
        end else begin
          sub_q <= sub_q + SUB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= report_i.action;
      s1_hit_q    <= in_hit;
      s1_port_q   <= report_i.port_number;
      s1_total_q  <= report_i.rx_count + report_i.tx_count;
    end
    if (wr_en) begin
      fwd_addr_q  <= s1_addr;
      fwd_total_q <= s1_total_q;
    end
  end

  plar_total_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_acc && in_hit),
    .rd_addr_i  (report_i.port_number[ADDR_W-1:0]),
    .rd_total_o (rd_total),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_addr),
    .wr_data_i  (s1_total_q)
  );

  plar_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (marker_go),
    .words_i (load_words),
    .empty_o (buf_empty),
    .chain_o (chain_o)
  );

  `PLAR_ASSERT_SAME(a_stall_only_on_marker, !report_i.ready, s1_valid_q && s1_action_q,
                    "report_i held without a pending marker")
  `PLAR_ASSERT_SAME(a_load_into_empty, marker_go, !chain_o.valid,
                    "chain words loaded over undelivered beats")
  `PLAR_ASSERT_NEXT(a_chain_cleared, marker_go, chain_q[0] == 64'd0 && chain_q[1] == 64'd0,
                    "chain words not cleared after end of poll")
  `PLAR_ASSERT_NEXT(a_poll_advance, marker_go, poll_q == $past(poll_q) + 32'd1,
                    "poll counter did not advance on end of poll")

endmodule

@@ verif/tb_port_link_activity_led_render.sv @@
localparam int unsigned PORT_COUNT   = 52;
localparam int unsigned BLINK_PERIOD = 8;
localparam int unsigned RUN_LIMIT    = 500000;

typedef struct {
  bit        action;
  bit [7:0]  port;
  bit        entry_valid;
  bit        link;
  bit [63:0] rx;
  bit [63:0] tx;
} port_report_t;

typedef struct {
  bit        processor;
  bit [63:0] bits;
  bit        last;
} chain_word_t;

class led_scoreboard;
  bit [63:0]    port_total [PORT_COUNT + 1];
  bit [63:0]    lit_chain [2];
  bit [31:0]    polls_done;
  byte unsigned amber_pos [PORT_COUNT + 1];
  chain_word_t  pending_words [$];
  int unsigned  failures;

  function new();
    amber_pos = '{0,
                  34, 32, 38, 36, 62, 60, 58, 56,
                  2,  0,  6,  4,  50, 48, 54, 52,
                  46, 44, 42, 40, 62, 60, 58, 56,
                  38, 36, 34, 32, 30, 28, 26, 24,
                  14, 8,  10, 12, 22, 20, 18, 16,
                  44, 42, 40, 46, 52, 50, 48, 54,
                  26, 24, 30, 28};
  endfunction

  function void note_report(port_report_t r);
    chain_word_t w;
    bit [63:0]   total;
    bit          busy;
    bit          blink_dark;
    bit          chain_sel;
    if (r.action) begin
      for (int c = 0; c < 2; c++) begin
        w.processor = c[0];
        w.bits      = lit_chain[c];
        w.last      = (c == 1);
        pending_words.push_back(w);
      end
      lit_chain[0] = '0;
      lit_chain[1] = '0;
      polls_done++;
      return;
    end
    if (r.port == 0 || r.port > PORT_COUNT || !r.entry_valid || !r.link) begin
      return;
    end
    total = r.rx + r.tx;
    busy = (total != port_total[r.port]);
    blink_dark = ((polls_done / BLINK_PERIOD) % 2) != 0;
    port_total[r.port] = total;
    if (busy && blink_dark) begin
      return;
    end
    chain_sel = (r.port <= 8) || (r.port >= 41);
    lit_chain[chain_sel][(amber_pos[r.port] + 1) % 64] = 1'b1;
  endfunction

  function void check_word(logic processor, logic [63:0] bits, logic last);
    chain_word_t w;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected chain word: processor=%0d bits=%h last=%0d",
               $time, processor, bits, last);
      failures++;
      return;
    end
    w = pending_words.pop_front();
    if (w.processor !== processor || w.bits !== bits || w.last !== last) begin
      $display("%0t: chain word mismatch: expected processor=%0d bits=%h last=%0d",
               $time, w.processor, w.bits, w.last);
      $display("%0t:                      actual   processor=%0d bits=%h last=%0d",
               $time, processor, bits, last);
      failures++;
    end
  endfunction
endclass

module tb_port_link_activity_led_render;

  logic clk_i;
  logic rst_ni;

  plar_in_if  report_if ();
  plar_out_if chain_if ();

  port_link_activity_led_render i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .report_i(report_if),
    .chain_o (chain_if)
  );

  led_scoreboard sb = new();

  bit          calm;
  bit          hold_request;
  int unsigned cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && chain_if.valid === 1'b1 && chain_if.ready === 1'b1) begin
      sb.check_word(chain_if.processor, chain_if.chain_bits, chain_if.last);
    end
  end

  initial begin
    bit choppy;
    chain_if.ready <= 1'b0;
    choppy = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) begin
        choppy = ~choppy;
      end
      if (hold_request) begin
        chain_if.ready <= 1'b0;
        repeat (299) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!calm && choppy && $urandom_range(0, 7) == 0) begin
        chain_if.ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(posedge clk_i);
      end else begin
        chain_if.ready <= 1'b1;
      end
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic port_report_t make_report(bit action, bit [7:0] port, bit entry_valid,
                                               bit link, bit [63:0] rx, bit [63:0] tx);
    port_report_t r;
    r.action      = action;
    r.port        = port;
    r.entry_valid = entry_valid;
    r.link        = link;
    r.rx          = rx;
    r.tx          = tx;
    return r;
  endfunction

  task automatic send_report(port_report_t r);
    report_if.valid       <= 1'b1;
    report_if.action      <= r.action;
    report_if.port_number <= r.port;
    report_if.entry_valid <= r.entry_valid;
    report_if.link_up     <= r.link;
    report_if.rx_count    <= r.rx;
    report_if.tx_count    <= r.tx;
    do @(negedge clk_i); while (report_if.ready !== 1'b1);
    sb.note_report(r);
    @(posedge clk_i);
  endtask

  task automatic sender_gap(bit gappy);
    if (!calm && gappy && $urandom_range(0, 4) == 0) begin
      report_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  initial begin
    port_report_t r;
    bit [63:0]    rx_seen [PORT_COUNT + 1];
    bit [63:0]    tx_seen [PORT_COUNT + 1];
    int unsigned  counted;
    int unsigned  burst;
    int unsigned  p;
    int unsigned  mode;
    bit           gappy;

    rst_ni                <= 1'b0;
    report_if.valid       <= 1'b0;
    report_if.action      <= 1'b0;
    report_if.port_number <= '0;
    report_if.entry_valid <= 1'b0;
    report_if.link_up     <= 1'b0;
    report_if.rx_count    <= '0;
    report_if.tx_count    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_report(make_report(1, 0, 0, 0, 0, 0));
    send_report(make_report(0, 0, 1, 1, 64'd3, 64'd4));
    send_report(make_report(0, 53, 1, 1, 64'd3, 64'd4));
    send_report(make_report(0, 255, 1, 1, '1, '1));
    send_report(make_report(0, 1, 1, 1, 0, 0));
    send_report(make_report(0, 52, 1, 1, '1, 64'd1));
    send_report(make_report(0, 9, 0, 1, 64'd5, 64'd7));
    send_report(make_report(0, 10, 1, 0, 64'd5, 64'd7));
    send_report(make_report(0, 9, 1, 1, 64'd5, 64'd7));
    send_report(make_report(0, 9, 1, 1, 64'd7, 64'd5));
    send_report(make_report(0, 5, 1, 1, '1, '1));
    send_report(make_report(0, 33, 1, 1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000));
    send_report(make_report(1, 0, 0, 0, 0, 0));
    send_report(make_report(0, 10, 1, 1, 0, 0));
    send_report(make_report(0, 10, 1, 1, 64'd1, 0));
    send_report(make_report(1, 8'hFF, 1, 1, '1, '1));

    hold_request = 1'b1;
    counted = 0;
    while (counted < 1950) begin
      if (counted > 1750) begin
        calm = 1'b1;
      end
      gappy = ($urandom_range(0, 2) != 0);
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 85) begin
          p = $urandom_range(1, PORT_COUNT);
          mode = $urandom_range(0, 9);
          if (mode >= 8) begin
            rx_seen[p] = rand64();
            tx_seen[p] = rand64();
          end else if (mode >= 4) begin
            rx_seen[p] += 64'($urandom_range(0, 100));
            tx_seen[p] += 64'($urandom_range(0, 100));
          end
          r = make_report(0, p[7:0], 1, 1, rx_seen[p], tx_seen[p]);
        end else begin
          r = make_report(0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), rand64(), rand64());
        end
        send_report(r);
        counted++;
        sender_gap(gappy);
      end
      send_report(make_report(1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), rand64(), rand64()));
      counted++;
      sender_gap(gappy);
    end
    report_if.valid <= 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
